FILE: rtl/sweep_prune_pair_finder_top_assert.svh
// Assertion macros used by the block's top module.
`ifndef SWEEP_PRUNE_PAIR_FINDER_TOP_ASSERT_SVH
`define SWEEP_PRUNE_PAIR_FINDER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SPF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants and types of the sweep-and-prune pair finder.
// ----------------------------------------------------------------------------
`default_nettype none
package spf_pkg;
  localparam int unsigned MaxBoxesDef = 8;
  localparam int unsigned MaxResultsDef = 28;
  localparam int unsigned IdxW = 3;
  localparam int unsigned BoundW = 32;
  localparam int unsigned MaskW = 8;
  localparam logic [0:0] RegFirstMask = 1'b0;
  localparam logic [0:0] RegSecondMask = 1'b1;
  typedef logic [BoundW-1:0] bound_t;
  typedef logic [MaskW-1:0] mask_t;

  // Signed compare a > b on two's complement values.
  function automatic logic signed_gt(input bound_t a, input bound_t b);
    signed_gt = $signed(a) > $signed(b);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/sweep_prune_pair_finder_top.sv
// ----------------------------------------------------------------------------
// sweep_prune_pair_finder_top
// Single-axis sweep-and-prune broadphase over a set of up to MAX_BOXES boxes.
// ----------------------------------------------------------------------------
// Usage: send boxes one beat each on the in_ channel; the beat's position in
// the set is the box index (absent boxes keep their slot). A beat with
// in_last_box set starts the sweep; beats beyond MAX_BOXES are dropped but a
// last flag on them still starts the sweep. Box data lives in one RAM (bounds
// and mask per slot, registered read). The sort walks the slots, skipping
// absent ones; for each present box it reads the key, compares it with the
// sorted entries from the end, shifts each larger one up a place and then
// inserts the box. The pair scan fetches each row's box and then tests it
// against the later boxes in sorted order. A found pair is held back until
// the next pair is found or the scan ends, so that the final beat can carry
// out_last_pair; that final beat (or the single out_pair_valid low beat of an
// empty set) is registered in the done state. A stalled receiver holds the
// block in the sweep; no new box is taken until the set's last result beat
// is accepted, and the next set can start in the cycle after that.
// Reset clears the present flags, the slot count and sets both group masks
// to all ones. The cfg_ port (APB style) holds the two group masks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sweep_prune_pair_finder_top_assert.svh"
module sweep_prune_pair_finder_top
  import spf_pkg::*;
#(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_box_present,
  input  wire logic signed [31:0]  in_min_x,
  input  wire logic signed [31:0]  in_max_x,
  input  wire logic [7:0]          in_group_mask,
  input  wire logic                in_last_box,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_first_index,
  output logic [2:0]               out_second_index,
  output logic                     out_pair_valid,
  output logic                     out_last_pair,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned EW = 2 * BoundW + MaskW;
  localparam int unsigned RW = $clog2(MaxResultsDef + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // walk present flags for insertion
  localparam logic [3:0] S_KEYRD = 4'd2;  // key of box to insert read
  localparam logic [3:0] S_CMP   = 4'd3;  // read sorted[j-1] for the compare
  localparam logic [3:0] S_PA    = 4'd4;  // read box a
  localparam logic [3:0] S_PAW   = 4'd5;
  localparam logic [3:0] S_PB    = 4'd6;  // read box b
  localparam logic [3:0] S_PBW   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_CMPW  = 4'd10;

  // Configuration registers.
  mask_t m1_r, m2_r;
  logic  cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '1;
      m2_r <= '1;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == RegFirstMask) m1_r <= cfg_pwdata[7:0];
      else m2_r <= cfg_pwdata[7:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == RegFirstMask) cfg_prdata[7:0] = m1_r;
      else cfg_prdata[7:0] = m2_r;
    end
  end

  logic [3:0]           st_r, st_nxt;
  logic [CW-1:0]        loaded_r;
  logic [MAX_BOXES-1:0] pres_r;
  logic [AW-1:0]        ord_r [MAX_BOXES];  // sorted order, small register file
  logic [CW-1:0]        cnt_r, i_r, j_r, pi_r, pj_r;
  logic [RW-1:0]        emit_r;
  bound_t               key_r, hi_r;
  mask_t                ma_r;
  logic                 hold_r, fin_r, ov_r, ol_r, ovld_r;
  logic [AW-1:0]        hf_r, hs_r;
  logic [AW-1:0]        of_r, os_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  bound_t        r_lo, r_hi;
  mask_t         r_m;

  spf_ram #(.Width(EW), .Depth(MAX_BOXES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
  assign r_lo = rdata[EW-1 -: BoundW];
  assign r_hi = rdata[MaskW +: BoundW];
  assign r_m  = rdata[MaskW-1:0];

  logic in_acc, out_acc, room;
  assign in_ready = (st_r == S_LOAD);
  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign room = (loaded_r < CW'(MAX_BOXES));
  assign we = in_acc && room;
  assign waddr = loaded_r[AW-1:0];
  assign wdata = {in_min_x, in_max_x, in_group_mask};

  logic match;
  assign match = ((ma_r & m1_r) != '0 && (r_m & m2_r) != '0) ||
                 ((ma_r & m2_r) != '0 && (r_m & m1_r) != '0);

  logic [AW-1:0] jm1;
  assign jm1 = AW'(j_r - CW'(1));

  always_comb begin
    raddr = i_r[AW-1:0];
    unique case (st_r) inside
      S_SCAN, S_KEYRD: raddr = i_r[AW-1:0];
      S_CMP, S_CMPW:   raddr = ord_r[jm1];
      S_PA, S_PAW:     raddr = ord_r[pi_r[AW-1:0]];
      S_PB, S_PBW:     raddr = ord_r[pj_r[AW-1:0]];
      default:         raddr = i_r[AW-1:0];
    endcase
  end

  assign out_valid = ovld_r;
  assign out_first_index = 3'(of_r);
  assign out_second_index = 3'(os_r);
  assign out_pair_valid = ov_r;
  assign out_last_pair = ol_r;

  logic brk_c, pair_hit;
  assign brk_c = (st_r == S_PBW) && signed_gt(r_lo, hi_r);
  assign pair_hit = !signed_gt(r_lo, hi_r) && match;

  // Next pair position after (pi, pj) has been resolved; "brk" ends row pi.
  logic          adv_done;
  logic [CW-1:0] npi, npj;
  always_comb begin
    npi = pi_r;
    npj = pj_r + CW'(1);
    if (brk_c || npj >= cnt_r) begin
      npi = pi_r + CW'(1);
      npj = pi_r + CW'(2);
    end
    adv_done = (npj >= cnt_r) || (npi + CW'(1) >= cnt_r);
  end

  // The scan ends when no pair is left or the result limit is reached.
  logic sweep_end;
  assign sweep_end = adv_done || (pair_hit && emit_r == RW'(MaxResultsDef - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      loaded_r <= '0;
      pres_r <= '0;
      ovld_r <= 1'b0;
      cnt_r <= '0;
      emit_r <= '0;
      hold_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_acc) ovld_r <= 1'b0;
      unique case (st_r)
        S_LOAD: if (in_acc) begin
          if (room) begin
            pres_r[loaded_r[AW-1:0]] <= in_box_present;
            loaded_r <= loaded_r + CW'(1);
          end
          i_r <= '0;
          cnt_r <= '0;
          emit_r <= '0;
          hold_r <= 1'b0;
          fin_r <= 1'b0;
        end
        S_SCAN: begin
          if (!(i_r < loaded_r && pres_r[i_r[AW-1:0]])) i_r <= i_r + CW'(1);
          j_r <= cnt_r;
        end
        S_KEYRD: key_r <= r_lo;
        S_CMP: ;
        S_CMPW: begin
          if (j_r != '0 && signed_gt(r_lo, key_r)) begin
            ord_r[j_r[AW-1:0]] <= ord_r[jm1];
            j_r <= j_r - CW'(1);
          end else begin
            ord_r[j_r[AW-1:0]] <= i_r[AW-1:0];
            cnt_r <= cnt_r + CW'(1);
            i_r <= i_r + CW'(1);
          end
        end
        S_PA: begin
          pi_r <= pi_r;
        end
        S_PAW: begin
          hi_r <= r_hi;
          ma_r <= r_m;
        end
        S_PB: ;
        S_PBW: begin
          pi_r <= npi;
          pj_r <= npj;
          if (pair_hit) begin
            // The new pair is held; the one held before it goes out now.
            hf_r <= ord_r[pi_r[AW-1:0]];
            hs_r <= ord_r[pj_r[AW-1:0]];
            hold_r <= 1'b1;
            fin_r <= sweep_end;
            emit_r <= emit_r + RW'(1);
            if (hold_r) begin
              of_r <= hf_r;
              os_r <= hs_r;
              ov_r <= 1'b1;
              ol_r <= 1'b0;
              ovld_r <= 1'b1;
            end
          end
        end
        S_EMIT: ;
        S_DONE: begin
          if (!ovld_r) begin
            if (hold_r) begin
              of_r <= hf_r;
              os_r <= hs_r;
              ov_r <= 1'b1;
              hold_r <= 1'b0;
            end else begin
              of_r <= '0;
              os_r <= '0;
              ov_r <= 1'b0;
            end
            ol_r <= 1'b1;
            ovld_r <= 1'b1;
          end
          if (out_acc && ol_r) begin
            pres_r <= '0;
            loaded_r <= '0;
          end
        end
        default: ;
      endcase
      if (st_r == S_SCAN && !(i_r < loaded_r)) begin
        pi_r <= '0;
        pj_r <= CW'(1);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD:  if (in_acc && in_last_box) st_nxt = S_SCAN;
      S_SCAN: begin
        if (!(i_r < loaded_r)) begin
          st_nxt = (cnt_r >= CW'(2)) ? S_PA : S_DONE;
        end else if (pres_r[i_r[AW-1:0]]) st_nxt = S_KEYRD;
      end
      S_KEYRD: st_nxt = S_CMP;
      S_CMP:   st_nxt = S_CMPW;
      S_CMPW:  st_nxt = (j_r != '0 && signed_gt(r_lo, key_r)) ? S_CMP : S_SCAN;
      S_PA:    st_nxt = S_PAW;
      S_PAW:   st_nxt = S_PB;
      S_PB:    st_nxt = S_PBW;
      S_PBW: begin
        if (pair_hit && hold_r) st_nxt = S_EMIT;
        else if (sweep_end) st_nxt = S_DONE;
        else if (npi != pi_r) st_nxt = S_PA;
        else st_nxt = S_PB;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (fin_r) st_nxt = S_DONE;
          else st_nxt = (pj_r == pi_r + CW'(1)) ? S_PA : S_PB;
        end
      end
      S_DONE:  if (out_acc && ol_r) st_nxt = S_LOAD;
      default: st_nxt = S_LOAD;
    endcase
  end

  `SPF_ASSERT_IMPL(a_no_in_while_out, out_valid, !in_ready)
  `SPF_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_BOXES))
  `SPF_ASSERT_NEXT(a_last_back_load, out_acc && out_last_pair, st_r == S_LOAD)
endmodule
`default_nettype wire

FILE: rtl/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module spf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
